// ===== rtl/kce_pkg.sv =====
`default_nettype none

package kce_pkg;

   // Default text buffer size; one character slot is kept for the terminator
   localparam int BUF_CHARS_DEF = 16;

   // Two fields: latitude and longitude
   localparam int NUM_FIELDS = 2;

   // Widths of the datapath
   localparam int KEY_W  = 4;
   localparam int CNT_W  = 4;
   localparam int POS_W  = 4;
   localparam int FMT_W  = 2;
   localparam int DIG_W  = 4;
   localparam int LAT_W  = 28;
   localparam int LON_W  = 29;
   localparam int MAG_W  = 28;
   localparam int DEG_W  = 10;  // up to three degree digits
   localparam int P1_W   = 7;   // two digits
   localparam int P2_W   = 14;  // up to four digits
   localparam int MIN_W  = 20;  // MM*10000+MMMM or MM*60+SS
   localparam int SCL_W  = 24;  // scaled numerator, halved
   localparam int FRAC_W = 21;  // fraction of a degree in microdegrees
   localparam int SUM_W  = 30;  // degrees plus fraction
   localparam int PROD_W = 2 * SCL_W;

   // Last digit position any layout reads (three degree digits plus six)
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(8);

   // Key codes
   typedef logic [KEY_W-1:0] key_type;
   localparam key_type KEY_DIGIT_MAX = KEY_W'(8);
   localparam key_type KEY_TOGGLE    = KEY_W'(9);
   localparam key_type KEY_ZERO      = KEY_W'(10);
   localparam key_type KEY_DELETE    = KEY_W'(11);

   // Layout codes; the unused code reads as DMS
   typedef logic [FMT_W-1:0] fmt_type;
   localparam fmt_type FMT_DDM = FMT_W'(0);
   localparam fmt_type FMT_DD  = FMT_W'(1);
   localparam fmt_type FMT_DMS = FMT_W'(2);

   // Reciprocal constants: floor(y/3) = (y*DDM_MAGIC) >> 25, floor(y/9) = (y*DMS_MAGIC) >> 27
   localparam logic [SCL_W-1:0] DDM_MAGIC = 24'hAAAAAB;
   localparam int               DDM_SHIFT = 25;
   localparam logic [SCL_W-1:0] DMS_MAGIC = 24'hE38E39;
   localparam int               DMS_SHIFT = 27;

   localparam logic [SUM_W-1:0] UDEG_PER_DEG = SUM_W'(1000000);
   localparam logic [SUM_W-1:0] LAT_MAX_UDEG = SUM_W'(90000000);
   localparam logic [SUM_W-1:0] LON_MAX_UDEG = SUM_W'(180000000);

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIGITS,
      ST_COMBINE,
      ST_SCALE,
      ST_DIVIDE,
      ST_SUM,
      ST_OUT
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic edit;
      logic step;
      logic combine;
      logic scale;
      logic divide;
      logic sum;
      logic load;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic last_digit;
      logic out_free;
   } status_type;

   // Degree digits of a field: two for latitude, three for longitude
   function automatic logic [POS_W-1:0] deg_digits(input logic is_lon);
      return is_lon ? POS_W'(3) : POS_W'(2);
   endfunction

   // Magnitude limit of a field
   function automatic logic [SUM_W-1:0] max_udeg(input logic is_lon);
      return is_lon ? LON_MAX_UDEG : LAT_MAX_UDEG;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/keypad_coordinate_entry.sv =====
// Keypad coordinate entry.
// Input channel (req_valid / req_stall): one key press per transfer, req_key_code
// (0..8 digits one to nine, 9 hemisphere toggle, 10 digit zero, 11 delete) aimed at
// latitude (req_target_field 0) or longitude (1).
// Result channel (rsp_valid / rsp_stall): one transfer per press with both signed
// coordinates in microdegrees, the position-valid flag and both digit counts.
// Config channel (csr_valid / csr_ready): writes coord_format, 0 DDM, 1 DD, 2 DMS;
// write only while no press is in flight. csr_ready is always high.
// A press is taken only in the idle state, after the previous result has been loaded.
// The position counter walks nine digit positions, one a cycle, followed by combine,
// scale, reciprocal divide, sum/clamp and load steps.
// The output register frees the input side: the next press may be taken while a
// result still waits on a stalled receiver; if the receiver still stalls when the
// next result is ready, the block holds it and stalls its input.
// Reset (synchronous): both fields empty, latitude north, longitude west,
// format DDM, no result pending.
`default_nettype none

module keypad_coordinate_entry
   import kce_pkg::*;
#(
   parameter int BUF_CHARS = BUF_CHARS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [KEY_W-1:0]    req_key_code,
   input  wire logic                req_target_field,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic signed [LAT_W-1:0]  rsp_latitude_udeg,
   output logic signed [LON_W-1:0]  rsp_longitude_udeg,
   output logic                     rsp_position_valid,
   output logic [CNT_W-1:0]         rsp_lat_count,
   output logic [CNT_W-1:0]         rsp_lon_count,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [FMT_W-1:0]    csr_coord_format
);

   cmd_type    cmd;
   status_type status;

   kce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   kce_dpath #(
      .BUF_CHARS (BUF_CHARS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_key_code       (req_key_code),
      .req_target_field   (req_target_field),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_coord_format   (csr_coord_format),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_latitude_udeg  (rsp_latitude_udeg),
      .rsp_longitude_udeg (rsp_longitude_udeg),
      .rsp_position_valid (rsp_position_valid),
      .rsp_lat_count      (rsp_lat_count),
      .rsp_lon_count      (rsp_lon_count)
   );

endmodule

`default_nettype wire

// ===== rtl/kce_ctrl.sv =====
`default_nettype none

module kce_ctrl
   import kce_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire status_type  status,
   output cmd_type          cmd
);

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.edit = 1'b1;
               state_in = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            cmd.step = 1'b1;
            if (status.last_digit) begin
               state_in = ST_COMBINE;
            end
         end
         ST_COMBINE: begin
            cmd.combine = 1'b1;
            state_in    = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.divide = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold the result until the output register is free
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/kce_dpath.sv =====
`default_nettype none

module kce_dpath
   import kce_pkg::*;
#(
   parameter int BUF_CHARS = BUF_CHARS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   output status_type               status,
   input  wire logic [KEY_W-1:0]    req_key_code,
   input  wire logic                req_target_field,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [FMT_W-1:0]    csr_coord_format,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic signed [LAT_W-1:0]  rsp_latitude_udeg,
   output logic signed [LON_W-1:0]  rsp_longitude_udeg,
   output logic                     rsp_position_valid,
   output logic [CNT_W-1:0]         rsp_lat_count,
   output logic [CNT_W-1:0]         rsp_lon_count
);

   localparam int               CAP     = BUF_CHARS - 1;
   localparam int               IDX_W   = $clog2(CAP);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAP);

   // Configuration and editing state
   fmt_type              fmt_ff;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [CNT_W-1:0]     len_ff  [NUM_FIELDS];
   logic [CNT_W-1:0]     len_in  [NUM_FIELDS];
   logic                 hemi_ff [NUM_FIELDS];
   logic                 hemi_in [NUM_FIELDS];
   logic [DIG_W-1:0]     store_ff [NUM_FIELDS][CAP];
   logic [DIG_W-1:0]     rd_digit_ff [NUM_FIELDS];
   logic                 wr_en   [NUM_FIELDS];
   logic [DIG_W-1:0]     wr_digit;
   logic                 is_digit_key;
   logic                 fmt_dd, fmt_dms;
   logic [POS_W-1:0]     frac2_digits;

   // Per-field conversion registers
   logic [DEG_W-1:0]     deg_ff  [NUM_FIELDS];
   logic [DEG_W-1:0]     deg_in  [NUM_FIELDS];
   logic [P1_W-1:0]      p1_ff   [NUM_FIELDS];
   logic [P1_W-1:0]      p1_in   [NUM_FIELDS];
   logic [P2_W-1:0]      p2_ff   [NUM_FIELDS];
   logic [P2_W-1:0]      p2_in   [NUM_FIELDS];
   logic [MIN_W-1:0]     min_ff  [NUM_FIELDS];
   logic [MIN_W-1:0]     min_in  [NUM_FIELDS];
   logic [SCL_W-1:0]     scl_ff  [NUM_FIELDS];
   logic [SCL_W-1:0]     scl_in  [NUM_FIELDS];
   logic [FRAC_W-1:0]    frac_ff [NUM_FIELDS];
   logic [FRAC_W-1:0]    frac_in [NUM_FIELDS];
   logic [SUM_W-1:0]     degs_ff [NUM_FIELDS];
   logic [SUM_W-1:0]     degs_in [NUM_FIELDS];
   logic [MAG_W-1:0]     mag_ff  [NUM_FIELDS];
   logic [MAG_W-1:0]     mag_in  [NUM_FIELDS];

   // Output register
   logic                 rsp_valid_ff;
   logic [LAT_W-1:0]     lat_ff, lat_in;
   logic [LON_W-1:0]     lon_ff, lon_in;
   logic                 pvalid_ff, pvalid_in;
   logic [CNT_W-1:0]     latc_ff, lonc_ff;

   assign csr_ready = 1'b1;

   assign fmt_dd       = (fmt_ff == FMT_DD);
   assign fmt_dms      = (fmt_ff != FMT_DD) && (fmt_ff != FMT_DDM);
   assign frac2_digits = fmt_dms ? POS_W'(2) : POS_W'(4);

   // Key decode
   assign wr_digit     = (req_key_code == KEY_ZERO) ? DIG_W'(0) : req_key_code + KEY_W'(1);
   assign is_digit_key = (req_key_code <= KEY_DIGIT_MAX) || (req_key_code == KEY_ZERO);

   // Position counter walks the digit strings
   always_comb begin
      pos_in = pos_ff;
      if (cmd.edit) begin
         pos_in = '0;
      end else if (cmd.step) begin
         pos_in = pos_ff + POS_W'(1);
      end
   end

   // Edit, digit accumulation and arithmetic for both fields
   always_comb begin
      for (int f = 0; f < NUM_FIELDS; f++) begin
         logic                sel;
         logic [DIG_W-1:0]    dig;
         logic [POS_W-1:0]    dw;
         logic [SCL_W+1:0]    wide;
         logic [PROD_W-1:0]   prod;
         logic [SUM_W-1:0]    total;
         logic [SUM_W-1:0]    limit;

         sel   = (req_target_field == 1'(f));
         dw    = deg_digits(1'(f));
         limit = max_udeg(1'(f));

         // apply the key press
         len_in[f]  = len_ff[f];
         hemi_in[f] = hemi_ff[f];
         wr_en[f]   = 1'b0;
         if (cmd.edit && sel) begin
            if (req_key_code == KEY_DELETE) begin
               if (len_ff[f] != '0) begin
                  len_in[f] = len_ff[f] - CNT_W'(1);
               end
            end else if (req_key_code == KEY_TOGGLE) begin
               hemi_in[f] = !hemi_ff[f];
            end else if (is_digit_key && (len_ff[f] < CAP_CNT)) begin
               wr_en[f]  = 1'b1;
               len_in[f] = len_ff[f] + CNT_W'(1);
            end
         end

         // one digit per step; positions past the count read as zero
         dig = (pos_ff < len_ff[f]) ? rd_digit_ff[f] : DIG_W'(0);
         deg_in[f] = deg_ff[f];
         p1_in[f]  = p1_ff[f];
         p2_in[f]  = p2_ff[f];
         if (cmd.edit) begin
            deg_in[f] = '0;
            p1_in[f]  = '0;
            p2_in[f]  = '0;
         end else if (cmd.step) begin
            if (pos_ff < dw) begin
               deg_in[f] = DEG_W'(deg_ff[f] * DEG_W'(10) + DEG_W'(dig));
            end else if (pos_ff < dw + POS_W'(2)) begin
               p1_in[f] = P1_W'(p1_ff[f] * P1_W'(10) + P1_W'(dig));
            end else if (pos_ff < dw + POS_W'(2) + frac2_digits) begin
               p2_in[f] = P2_W'(p2_ff[f] * P2_W'(10) + P2_W'(dig));
            end
         end

         // minutes (or seconds, or fraction) as one number
         min_in[f] = min_ff[f];
         if (cmd.combine) begin
            if (fmt_dms) begin
               min_in[f] = MIN_W'(p1_ff[f]) * MIN_W'(60) + MIN_W'(p2_ff[f]);
            end else begin
               min_in[f] = MIN_W'(p1_ff[f]) * MIN_W'(10000) + MIN_W'(p2_ff[f]);
            end
         end

         // scaled numerator with rounding offset, halved; DD takes the fraction unscaled
         if (fmt_dms) begin
            wide = (SCL_W+2)'(min_ff[f]) * (SCL_W+2)'(5000) + (SCL_W+2)'(9);
         end else begin
            wide = (SCL_W+2)'(min_ff[f]) * (SCL_W+2)'(10) + (SCL_W+2)'(3);
         end
         scl_in[f] = scl_ff[f];
         if (cmd.scale) begin
            scl_in[f] = fmt_dd ? SCL_W'(min_ff[f]) : wide[SCL_W:1];
         end

         // divide by 3 or 9 through a reciprocal (DD passes through); scale the degrees
         prod = PROD_W'(scl_ff[f]) * PROD_W'(fmt_dms ? DMS_MAGIC : DDM_MAGIC);
         frac_in[f] = frac_ff[f];
         degs_in[f] = degs_ff[f];
         if (cmd.divide) begin
            if (fmt_dd) begin
               frac_in[f] = FRAC_W'(scl_ff[f]);
            end else if (fmt_dms) begin
               frac_in[f] = prod[DMS_SHIFT +: FRAC_W];
            end else begin
               frac_in[f] = prod[DDM_SHIFT +: FRAC_W];
            end
            degs_in[f] = SUM_W'(deg_ff[f]) * UDEG_PER_DEG;
         end

         // add and clamp
         total     = degs_ff[f] + SUM_W'(frac_ff[f]);
         mag_in[f] = mag_ff[f];
         if (cmd.sum) begin
            mag_in[f] = (total > limit) ? MAG_W'(limit) : MAG_W'(total);
         end
      end
   end

   // Signed result
   always_comb begin
      pvalid_in = (len_ff[0] != '0) || (len_ff[1] != '0);
      lat_in    = '0;
      lon_in    = '0;
      if (pvalid_in) begin
         lat_in = hemi_ff[0] ? LAT_W'(mag_ff[0]) : LAT_W'(0) - LAT_W'(mag_ff[0]);
         lon_in = hemi_ff[1] ? LON_W'(mag_ff[1]) : LON_W'(0) - LON_W'(mag_ff[1]);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff       <= FMT_DDM;
         pos_ff       <= '0;
         len_ff[0]    <= '0;
         len_ff[1]    <= '0;
         hemi_ff[0]   <= 1'b1;
         hemi_ff[1]   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            fmt_ff <= csr_coord_format;
         end
         pos_ff <= pos_in;
         for (int f = 0; f < NUM_FIELDS; f++) begin
            len_ff[f]  <= len_in[f];
            hemi_ff[f] <= hemi_in[f];
         end
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      for (int f = 0; f < NUM_FIELDS; f++) begin
         deg_ff[f]  <= deg_in[f];
         p1_ff[f]   <= p1_in[f];
         p2_ff[f]   <= p2_in[f];
         min_ff[f]  <= min_in[f];
         scl_ff[f]  <= scl_in[f];
         frac_ff[f] <= frac_in[f];
         degs_ff[f] <= degs_in[f];
         mag_ff[f]  <= mag_in[f];
      end
      if (cmd.load) begin
         lat_ff    <= lat_in;
         lon_ff    <= lon_in;
         pvalid_ff <= pvalid_in;
         latc_ff   <= len_ff[0];
         lonc_ff   <= len_ff[1];
      end
   end

   // Digit stores, written at the current count and read one position ahead;
   // a digit written at the position being fetched is passed straight through
   always_ff @(posedge clock) begin
      for (int f = 0; f < NUM_FIELDS; f++) begin
         if (wr_en[f]) begin
            store_ff[f][len_ff[f][IDX_W-1:0]] <= wr_digit;
         end
         if (wr_en[f] && (len_ff[f] == pos_in)) begin
            rd_digit_ff[f] <= wr_digit;
         end else begin
            rd_digit_ff[f] <= store_ff[f][pos_in[IDX_W-1:0]];
         end
      end
   end

   assign status.last_digit = (pos_ff == LAST_POS);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_latitude_udeg  = lat_ff;
   assign rsp_longitude_udeg = lon_ff;
   assign rsp_position_valid = pvalid_ff;
   assign rsp_lat_count      = latc_ff;
   assign rsp_lon_count      = lonc_ff;

   // A waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> status.out_free)
      else $error("result loaded while output register still held");

   // Delete on a non-empty latitude field drops one digit
   a_lat_delete: assert property (@(posedge clock) disable iff (reset)
      (cmd.edit && (req_key_code == KEY_DELETE) && !req_target_field && (len_ff[0] != '0))
      |=> (len_ff[0] == $past(len_ff[0]) - CNT_W'(1)))
      else $error("latitude delete did not shorten the field");

   // A digit on a longitude field with room grows it by one
   a_lon_append: assert property (@(posedge clock) disable iff (reset)
      (cmd.edit && is_digit_key && req_target_field && (len_ff[1] < CAP_CNT))
      |=> (len_ff[1] == $past(len_ff[1]) + CNT_W'(1)))
      else $error("longitude digit not appended");

   // Clamped magnitudes at the time of loading
   a_mag_limit: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> ((SUM_W'(mag_ff[0]) <= LAT_MAX_UDEG) && (SUM_W'(mag_ff[1]) <= LON_MAX_UDEG)))
      else $error("coordinate magnitude above limit");

endmodule

`default_nettype wire
